// File: rtl/atbt_pkg.sv
// ----------------------------------------------------------------------------
// atbt_pkg
// Shared constants, types and arithmetic helpers of the affine transform
// bound tracker.
// ----------------------------------------------------------------------------
package atbt_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam int KIND_W = 3;
    localparam int ANG_W  = 24;
    localparam int VAL_W  = 32;
    localparam int DEV_W  = 24;
    localparam int MAT_W  = 32;
    localparam int ORG_W  = 40;
    localparam int IDX_W  = 5;

    localparam logic [KIND_W-1:0] K_ROTATE    = 3'd0;
    localparam logic [KIND_W-1:0] K_TRANSLATE = 3'd1;
    localparam logic [KIND_W-1:0] K_SCALE     = 3'd2;
    localparam logic [KIND_W-1:0] K_POINT     = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR     = 3'd4;

    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam int ANG_BIAS     = 92 * FULL_TURN;
    localparam int RED_W        = 25;
    localparam int RED_STEPS    = 8;
    localparam int FOLD_W       = 18;
    localparam int RAD_W        = 35;
    localparam logic signed [RAD_W-1:0] RAD_SCALE = 35'sd4797524518;

    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ROT_SHIFT = 30;

    localparam int PROD_W = CW + MAT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIDE_W = SUM_W + 1;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic             load;
        logic             red_step;
        logic             ang_load;
        logic             cor_step;
        logic             mul_issue;
        logic             commit;
        logic [IDX_W-1:0] idx;
    } atbt_cmd_t;

    function automatic wide_t sat_w(input wide_t v, input int w);
        wide_t lim;
        lim = wide_t'(1) <<< (w - 1);
        if (v > lim - wide_t'(1)) begin
            return lim - wide_t'(1);
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic logic signed [CW-1:0] atan_val(input logic [IDX_W-1:0] i);
        logic [31:0] t;
        case (i)
            5'd0:    t = 32'h3243F6A8;
            5'd1:    t = 32'h1DAC6705;
            5'd2:    t = 32'h0FADBAFC;
            5'd3:    t = 32'h07F56EA6;
            5'd4:    t = 32'h03FEAB76;
            5'd5:    t = 32'h01FFD55B;
            5'd6:    t = 32'h00FFFAAA;
            5'd7:    t = 32'h007FFF55;
            5'd8:    t = 32'h003FFFEA;
            5'd9:    t = 32'h001FFFFD;
            5'd10:   t = 32'h000FFFFF;
            5'd11:   t = 32'h0007FFFF;
            5'd12:   t = 32'h0003FFFF;
            5'd13:   t = 32'h0001FFFF;
            5'd14:   t = 32'h0000FFFF;
            5'd15:   t = 32'h00007FFF;
            5'd16:   t = 32'h00003FFF;
            5'd17:   t = 32'h00001FFF;
            5'd18:   t = 32'h00000FFF;
            5'd19:   t = 32'h000007FF;
            5'd20:   t = 32'h000003FF;
            5'd21:   t = 32'h000001FF;
            5'd22:   t = 32'h000000FF;
            5'd23:   t = 32'h0000007F;
            5'd24:   t = 32'h0000003F;
            5'd25:   t = 32'h0000001F;
            5'd26:   t = 32'h0000000F;
            5'd27:   t = 32'h00000008;
            5'd28:   t = 32'h00000004;
            5'd29:   t = 32'h00000002;
            5'd30:   t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return signed'({2'b00, t});
    endfunction

endpackage

// File: rtl/atbt_ctrl.sv
// ----------------------------------------------------------------------------
// atbt_ctrl
// Command sequencer: angle reduction, CORDIC steps, product issue and commit.
// ----------------------------------------------------------------------------
module atbt_ctrl import atbt_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic              out_busy,
    output atbt_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_ANGLE,
        S_CORDIC,
        S_MUL,
        S_DRAIN,
        S_COMMIT
    } state_t;

    localparam logic [IDX_W-1:0] COR_LAST = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] RED_LAST = IDX_W'(RED_STEPS - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] last_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.idx       = cnt_reg;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.red_step  = (state_reg == S_REDUCE);
        cmd.ang_load  = (state_reg == S_ANGLE);
        cmd.cor_step  = (state_reg == S_CORDIC);
        cmd.mul_issue = (state_reg == S_MUL);
        cmd.commit    = (state_reg == S_COMMIT) && !out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        case (kind)
                            K_ROTATE:
                            begin
                                state_reg <= S_REDUCE;
                            end
                            K_TRANSLATE, K_POINT:
                            begin
                                state_reg <= S_MUL;
                                last_reg  <= IDX_W'(3);
                            end
                            K_SCALE:
                            begin
                                state_reg <= S_MUL;
                                last_reg  <= IDX_W'(7);
                            end
                            default:
                            begin
                                state_reg <= S_COMMIT;
                            end
                        endcase
                    end
                end
                S_REDUCE:
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == RED_LAST)
                    begin
                        state_reg <= S_ANGLE;
                    end
                end
                S_ANGLE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (cnt_reg == COR_LAST)
                    begin
                        cnt_reg   <= '0;
                        last_reg  <= IDX_W'(7);
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + IDX_W'(1);
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == last_reg)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (!out_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.red_step, cmd.ang_load, cmd.cor_step, cmd.mul_issue, cmd.commit}))
        else $error("more than one datapath command");
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_busy)
        else $error("commit while result still pending");
    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_issue |-> (cnt_reg <= IDX_W'(7)))
        else $error("product index out of range");
`endif

endmodule

// File: rtl/atbt_datapath.sv
// ----------------------------------------------------------------------------
// atbt_datapath
// Transform state, CORDIC, shared multiplier, accumulator and bounding box.
// ----------------------------------------------------------------------------
module atbt_datapath import atbt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  atbt_cmd_t               cmd,
    input  logic [KIND_W-1:0]       kind,
    input  logic signed [ANG_W-1:0] angle,
    input  logic signed [VAL_W-1:0] x_val,
    input  logic signed [VAL_W-1:0] y_val,
    input  logic                    out_ready,
    output logic                    out_busy,
    output logic                    out_valid,
    output logic signed [DEV_W-1:0] dev_x,
    output logic signed [DEV_W-1:0] dev_y,
    output logic signed [DEV_W-1:0] box_low_x,
    output logic signed [DEV_W-1:0] box_low_y,
    output logic signed [DEV_W-1:0] box_high_x,
    output logic signed [DEV_W-1:0] box_high_y,
    output logic                    box_valid
);

    logic [KIND_W-1:0]       kind_reg;
    logic signed [VAL_W-1:0] xv_reg, yv_reg;
    logic [RED_W-1:0]        red_reg;
    logic                    neg_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg, cz_reg;
    logic signed [MAT_W-1:0] mat_a_reg, mat_b_reg, mat_c_reg, mat_d_reg;
    logic signed [ORG_W-1:0] org_x_reg, org_y_reg;
    logic signed [DEV_W-1:0] low_x_reg, low_y_reg, high_x_reg, high_y_reg;
    logic                    empty_reg;
    logic signed [PROD_W-1:0] prod_reg, acc_reg;
    logic [2:0]              prod_j_reg;
    logic                    prod_vld_reg;
    logic signed [SUM_W-1:0] dot_reg [4];
    logic                    out_valid_reg;
    logic signed [DEV_W-1:0] dev_x_reg, dev_y_reg;
    logic                    box_valid_reg;

    logic signed [RED_W:0]    red_init;
    logic [RED_W-1:0]         red_sub;
    logic signed [FOLD_W-1:0] f0, f1, f2;
    logic                     fneg;
    logic signed [FOLD_W+RAD_W-1:0] z_prod;
    logic signed [CW-1:0]     cdx, cdy, cat;
    logic signed [CW-1:0]     rx, ry, op_a;
    logic signed [MAT_W-1:0]  op_b;
    logic [2:0]               mj;
    logic signed [SUM_W-1:0]  sum, dot_sh;
    wide_t                    tx, ty, ox, oy;
    logic signed [DEV_W-1:0]  dvx, dvy;

    function automatic logic signed [DEV_W-1:0] to_dev(input wide_t t);
        wide_t v;
        v = t >>> FRAC_BITS;
        if (t < 0 && (t[FRAC_BITS-1:0] != '0))
        begin
            v = v + wide_t'(1);
        end
        v = sat_w(v, DEV_W);
        return v[DEV_W-1:0];
    endfunction

    assign out_busy   = out_valid_reg && !out_ready;
    assign out_valid  = out_valid_reg;
    assign dev_x      = dev_x_reg;
    assign dev_y      = dev_y_reg;
    assign box_low_x  = low_x_reg;
    assign box_low_y  = low_y_reg;
    assign box_high_x = high_x_reg;
    assign box_high_y = high_y_reg;
    assign box_valid  = box_valid_reg;

    always_comb
    begin
        red_init = RED_W'(ANG_BIAS) + (RED_W+1)'(angle);
        red_sub  = RED_W'(FULL_TURN) << (3'd7 - cmd.idx[2:0]);
        f0 = FOLD_W'(red_reg);
        f1 = (f0 > FOLD_W'(HALF_TURN)) ? f0 - FOLD_W'(FULL_TURN) : f0;
        fneg = 1'b0;
        f2 = f1;
        if (f1 > FOLD_W'(QUARTER_TURN))
        begin
            f2   = f1 - FOLD_W'(HALF_TURN);
            fneg = 1'b1;
        end
        else if (f1 < -FOLD_W'(QUARTER_TURN))
        begin
            f2   = f1 + FOLD_W'(HALF_TURN);
            fneg = 1'b1;
        end
        z_prod = f2 * RAD_SCALE;
        cdx = cy_reg >>> cmd.idx;
        cdy = cx_reg >>> cmd.idx;
        cat = atan_val(cmd.idx);
    end

    always_comb
    begin
        rx = neg_reg ? -cx_reg : cx_reg;
        ry = neg_reg ? -cy_reg : cy_reg;
        mj = cmd.idx[2:0];
        op_a = '0;
        op_b = '0;
        case (kind_reg)
            K_ROTATE:
            begin
                case (mj)
                    3'd0: begin op_a = rx;  op_b = mat_a_reg; end
                    3'd1: begin op_a = ry;  op_b = mat_c_reg; end
                    3'd2: begin op_a = rx;  op_b = mat_b_reg; end
                    3'd3: begin op_a = ry;  op_b = mat_d_reg; end
                    3'd4: begin op_a = rx;  op_b = mat_c_reg; end
                    3'd5: begin op_a = -ry; op_b = mat_a_reg; end
                    3'd6: begin op_a = rx;  op_b = mat_d_reg; end
                    default: begin op_a = -ry; op_b = mat_b_reg; end
                endcase
            end
            K_SCALE:
            begin
                case (mj)
                    3'd0: begin op_a = CW'(xv_reg); op_b = mat_a_reg; end
                    3'd2: begin op_a = CW'(xv_reg); op_b = mat_b_reg; end
                    3'd4: begin op_a = CW'(yv_reg); op_b = mat_c_reg; end
                    3'd6: begin op_a = CW'(yv_reg); op_b = mat_d_reg; end
                    default: begin op_a = '0; op_b = '0; end
                endcase
            end
            default:
            begin
                case (mj)
                    3'd0: begin op_a = CW'(xv_reg); op_b = mat_a_reg; end
                    3'd1: begin op_a = CW'(yv_reg); op_b = mat_c_reg; end
                    3'd2: begin op_a = CW'(xv_reg); op_b = mat_b_reg; end
                    default: begin op_a = CW'(yv_reg); op_b = mat_d_reg; end
                endcase
            end
        endcase
    end

    always_comb
    begin
        sum = SUM_W'(acc_reg) + SUM_W'(prod_reg);
        dot_sh = (kind_reg == K_ROTATE) ? (sum >>> ROT_SHIFT) : (sum >>> FRAC_BITS);
        tx  = wide_t'(org_x_reg) + wide_t'(dot_reg[0]);
        ty  = wide_t'(org_y_reg) + wide_t'(dot_reg[1]);
        ox  = sat_w(tx, ORG_W);
        oy  = sat_w(ty, ORG_W);
        dvx = to_dev(tx);
        dvy = to_dev(ty);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            xv_reg   <= x_val;
            yv_reg   <= y_val;
            red_reg  <= red_init[RED_W-1:0];
        end
        if (cmd.red_step && (red_reg >= red_sub))
        begin
            red_reg <= red_reg - red_sub;
        end
        if (cmd.ang_load)
        begin
            cz_reg  <= z_prod[16+CW-1:16];
            cx_reg  <= CORDIC_GAIN;
            cy_reg  <= '0;
            neg_reg <= fneg;
        end
        if (cmd.cor_step)
        begin
            if (!cz_reg[CW-1])
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - cat;
            end
            else
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + cat;
            end
        end
        if (cmd.mul_issue)
        begin
            prod_reg   <= op_a * op_b;
            prod_j_reg <= mj;
        end
        if (prod_vld_reg)
        begin
            if (!prod_j_reg[0])
            begin
                acc_reg <= prod_reg;
            end
            else
            begin
                dot_reg[prod_j_reg[2:1]] <= dot_sh;
            end
        end
        if (cmd.commit)
        begin
            dev_x_reg <= (kind_reg == K_POINT) ? dvx : '0;
            dev_y_reg <= (kind_reg == K_POINT) ? dvy : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_a_reg     <= MAT_W'(1) <<< FRAC_BITS;
            mat_b_reg     <= '0;
            mat_c_reg     <= '0;
            mat_d_reg     <= MAT_W'(1) <<< FRAC_BITS;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            low_x_reg     <= '0;
            low_y_reg     <= '0;
            high_x_reg    <= '0;
            high_y_reg    <= '0;
            empty_reg     <= 1'b1;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_issue;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                case (kind_reg)
                    K_ROTATE, K_SCALE:
                    begin
                        box_valid_reg <= !empty_reg;
                        mat_a_reg <= MAT_W'(sat_w(wide_t'(dot_reg[0]), MAT_W));
                        mat_b_reg <= MAT_W'(sat_w(wide_t'(dot_reg[1]), MAT_W));
                        mat_c_reg <= MAT_W'(sat_w(wide_t'(dot_reg[2]), MAT_W));
                        mat_d_reg <= MAT_W'(sat_w(wide_t'(dot_reg[3]), MAT_W));
                    end
                    K_TRANSLATE:
                    begin
                        box_valid_reg <= !empty_reg;
                        org_x_reg <= ox[ORG_W-1:0];
                        org_y_reg <= oy[ORG_W-1:0];
                    end
                    K_POINT:
                    begin
                        empty_reg     <= 1'b0;
                        box_valid_reg <= 1'b1;
                        if (empty_reg || dvx < low_x_reg)  low_x_reg  <= dvx;
                        if (empty_reg || dvx > high_x_reg) high_x_reg <= dvx;
                        if (empty_reg || dvy < low_y_reg)  low_y_reg  <= dvy;
                        if (empty_reg || dvy > high_y_reg) high_y_reg <= dvy;
                    end
                    K_CLEAR:
                    begin
                        empty_reg     <= 1'b1;
                        box_valid_reg <= 1'b0;
                        low_x_reg     <= '0;
                        low_y_reg     <= '0;
                        high_x_reg    <= '0;
                        high_y_reg    <= '0;
                    end
                    default:
                    begin
                        box_valid_reg <= !empty_reg;
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/affine_transform_bound_tracker_top.sv
// ----------------------------------------------------------------------------
// affine_transform_bound_tracker_top
// 2D current transformation with device point mapping and bounding box.
// ----------------------------------------------------------------------------
// One item is handled at a time. Rotate runs 8 angle reduction steps, the
// angle fold, CORDIC_STEPS (18) iterations of the CORDIC unit, eight products
// through the single shared multiplier, a drain and the commit. Translate
// and bound point issue four products, scale eight product slots, each one
// followed by the drain and the commit; clear and unused kinds go straight to
// the commit. The block is ready again in the same cycle that the result
// appears. A result waits in its output register while the next item is
// accepted; that item's commit then holds until the waiting result has been
// taken.
module affine_transform_bound_tracker_top import atbt_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [KIND_W-1:0]       kind,
    input  logic signed [ANG_W-1:0] angle,
    input  logic signed [VAL_W-1:0] x_val,
    input  logic signed [VAL_W-1:0] y_val,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DEV_W-1:0] dev_x,
    output logic signed [DEV_W-1:0] dev_y,
    output logic signed [DEV_W-1:0] box_low_x,
    output logic signed [DEV_W-1:0] box_low_y,
    output logic signed [DEV_W-1:0] box_high_x,
    output logic signed [DEV_W-1:0] box_high_y,
    output logic                    box_valid
);

    atbt_cmd_t cmd;
    logic      out_busy;

    atbt_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .out_busy (out_busy),
        .cmd      (cmd)
    );

    atbt_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .angle      (angle),
        .x_val      (x_val),
        .y_val      (y_val),
        .out_ready  (out_ready),
        .out_busy   (out_busy),
        .out_valid  (out_valid),
        .dev_x      (dev_x),
        .dev_y      (dev_y),
        .box_low_x  (box_low_x),
        .box_low_y  (box_low_y),
        .box_high_x (box_high_x),
        .box_high_y (box_high_y),
        .box_valid  (box_valid)
    );

endmodule
